FILE: hw/rtl/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types and codes of the streaming WAV header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

	// chunk and file tags as they build up little-endian in a 32-bit shift word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// only plain pcm at this sample width goes through
	localparam logic [15:0] PCM_FORMAT = 16'd1;
	localparam logic [15:0] PCM_BITS   = 16'd16;

	// entries in each of the two small queues
	localparam int unsigned Q_DEPTH = 2;

	// result status codes
	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_ACCEPT  = 3'd2,
		ST_REJECT  = 3'd3,
		ST_TRUNC   = 3'd4,
		ST_IGNORE  = 3'd5
	} status_t;

	// reject reason codes
	typedef enum logic [2:0] {
		RSN_NONE    = 3'd0,
		RSN_NO_RIFF = 3'd1,
		RSN_NO_WAVE = 3'd2,
		RSN_NOT_PCM = 3'd3,
		RSN_NOT_16  = 3'd4,
		RSN_NO_DATA = 3'd5
	} reason_t;

	// one stream byte with its framing marks
	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	// one result per stream byte
	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  reject_reason;
		logic [7:0]  payload_byte;
		logic        payload_end;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [31:0] payload_left;
	} out_item_t;

endpackage

FILE: hw/rtl/whp_in_q.sv
// ----------------------------------------------------------------------------
// whp_in_q
// Front end: two-entry byte queue that takes stream bytes from the source
// and presents the oldest one to the parser.
// ----------------------------------------------------------------------------
module whp_in_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  whp_pkg::in_item_t wr_item,
	output logic              rd_valid,
	output whp_pkg::in_item_t rd_item,
	input  logic              rd_take
);
	import whp_pkg::*;

	in_item_t   mem_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (count_q == 2'(Q_DEPTH));
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = push && !full;
	assign do_rd    = rd_take && rd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/whp_parser.sv
// ----------------------------------------------------------------------------
// whp_parser
// Back end: walks the RIFF/WAVE structure one byte per cycle unless stalled;
// captures the fmt fields, gates the data chunk and forms one result per byte.
// ----------------------------------------------------------------------------
module whp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  whp_pkg::in_item_t  in_item,
	output logic               in_take,
	input  logic               out_ready,
	output logic               out_push,
	output whp_pkg::out_item_t out_item
);
	import whp_pkg::*;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_BODY,
		PH_PAD,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [31:0] offset_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [15:0] fmt_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] remain_q;
	logic        pad_q;

	// state as seen by this byte (a first byte restarts from reset)
	phase_t      ph_c;
	logic [31:0] off_c;
	logic [31:0] tag_c;
	logic [31:0] len_c;
	logic [15:0] fmt_c;
	logic [15:0] chan_c;
	logic [31:0] rate_c;
	logic [15:0] bits_c;
	logic [31:0] rem_c;
	logic        pad_c;

	// next state
	phase_t      ph_n;
	logic [31:0] off_n;
	logic [31:0] tag_n;
	logic [31:0] len_n;
	logic [15:0] fmt_n;
	logic [15:0] chan_n;
	logic [31:0] rate_n;
	logic [15:0] bits_n;
	logic [31:0] rem_n;
	logic        pad_n;

	status_t     st;
	reason_t     rsn;
	logic [7:0]  pbyte;
	logic        pend;
	logic [7:0]  b;
	logic        fire;

	assign fire     = in_valid && out_ready;
	assign in_take  = fire;
	assign out_push = fire;
	assign b        = in_item.in_byte;

	// byte step
	always_comb begin
		if (in_item.first_byte) begin
			ph_c   = PH_RIFF;
			off_c  = '0;
			tag_c  = '0;
			len_c  = '0;
			fmt_c  = '0;
			chan_c = '0;
			rate_c = '0;
			bits_c = '0;
			rem_c  = '0;
			pad_c  = 1'b0;
		end else begin
			ph_c   = phase_q;
			off_c  = offset_q;
			tag_c  = tag_q;
			len_c  = len_q;
			fmt_c  = fmt_q;
			chan_c = chan_q;
			rate_c = rate_q;
			bits_c = bits_q;
			rem_c  = remain_q;
			pad_c  = pad_q;
		end

		ph_n   = ph_c;
		off_n  = off_c;
		tag_n  = tag_c;
		len_n  = len_c;
		fmt_n  = fmt_c;
		chan_n = chan_c;
		rate_n = rate_c;
		bits_n = bits_c;
		rem_n  = rem_c;
		pad_n  = pad_c;
		st     = ST_IGNORE;
		rsn    = RSN_NONE;
		pbyte  = 8'd0;
		pend   = 1'b0;

		case (ph_c)
			PH_RIFF: begin
				st    = ST_HEADER;
				tag_n = {b, tag_c[31:8]};
				if (off_c == 32'd3 && tag_n != TAG_RIFF) begin
					st   = ST_REJECT;
					rsn  = RSN_NO_RIFF;
					ph_n = PH_DONE;
				end else if (off_c == 32'd11) begin
					if (tag_n != TAG_WAVE) begin
						st   = ST_REJECT;
						rsn  = RSN_NO_WAVE;
						ph_n = PH_DONE;
					end else begin
						ph_n  = PH_HDR;
						off_n = '0;
					end
				end else begin
					off_n = off_c + 32'd1;
				end
			end
			PH_HDR: begin
				st = ST_HEADER;
				if (off_c < 32'd4) begin
					tag_n = {b, tag_c[31:8]};
				end else begin
					len_n = {b, len_c[31:8]};
				end
				if (off_c != 32'd7) begin
					off_n = off_c + 32'd1;
				end else begin
					off_n = '0;
					if (tag_n == TAG_DATA) begin
						if (fmt_c != PCM_FORMAT) begin
							st   = ST_REJECT;
							rsn  = RSN_NOT_PCM;
							ph_n = PH_DONE;
						end else if (bits_c != PCM_BITS) begin
							st   = ST_REJECT;
							rsn  = RSN_NOT_16;
							ph_n = PH_DONE;
						end else begin
							st    = ST_ACCEPT;
							rem_n = len_n;
							ph_n  = (len_n != '0) ? PH_PAYLOAD : PH_DONE;
							if (in_item.last_byte && len_n != '0) begin
								st = ST_TRUNC;
							end
						end
					end else begin
						if (tag_n == TAG_FMT) begin
							fmt_n  = '0;
							chan_n = '0;
							rate_n = '0;
							bits_n = '0;
						end
						pad_n = len_n[0];
						ph_n  = (len_n != '0) ? PH_BODY : PH_HDR;
					end
				end
			end
			PH_BODY: begin
				st = ST_HEADER;
				// fmt field capture, little-endian
				if (tag_c == TAG_FMT && off_c[31:4] == 28'd0) begin
					case (off_c[3:0])
						4'd0:    fmt_n[7:0]    = fmt_c[7:0] | b;
						4'd1:    fmt_n[15:8]   = fmt_c[15:8] | b;
						4'd2:    chan_n[7:0]   = chan_c[7:0] | b;
						4'd3:    chan_n[15:8]  = chan_c[15:8] | b;
						4'd4:    rate_n[7:0]   = rate_c[7:0] | b;
						4'd5:    rate_n[15:8]  = rate_c[15:8] | b;
						4'd6:    rate_n[23:16] = rate_c[23:16] | b;
						4'd7:    rate_n[31:24] = rate_c[31:24] | b;
						4'd14:   bits_n[7:0]   = bits_c[7:0] | b;
						4'd15:   bits_n[15:8]  = bits_c[15:8] | b;
						default: fmt_n = fmt_c;
					endcase
				end
				if (off_c == len_c - 32'd1) begin
					off_n = '0;
					ph_n  = pad_c ? PH_PAD : PH_HDR;
				end else begin
					off_n = off_c + 32'd1;
				end
			end
			PH_PAD: begin
				st    = ST_HEADER;
				pad_n = 1'b0;
				off_n = '0;
				ph_n  = PH_HDR;
			end
			PH_PAYLOAD: begin
				rem_n = rem_c - 32'd1;
				pbyte = b;
				st    = ST_PAYLOAD;
				if (rem_n == '0) begin
					pend = 1'b1;
					ph_n = PH_DONE;
				end else if (in_item.last_byte) begin
					st = ST_TRUNC;
				end
			end
			default: begin
				st = ST_IGNORE;
			end
		endcase

		// end of stream
		if (in_item.last_byte) begin
			if (st == ST_HEADER) begin
				st  = ST_REJECT;
				rsn = RSN_NO_DATA;
			end
			ph_n = PH_DONE;
		end
	end

	// result for this byte
	always_comb begin
		out_item.status        = st;
		out_item.reject_reason = rsn;
		out_item.payload_byte  = pbyte;
		out_item.payload_end   = pend;
		out_item.channels      = chan_n;
		out_item.sample_rate   = rate_n;
		out_item.payload_left  = rem_n;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			offset_q <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			fmt_q    <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			bits_q   <= '0;
			remain_q <= '0;
			pad_q    <= 1'b0;
		end else if (fire) begin
			phase_q  <= ph_n;
			offset_q <= off_n;
			tag_q    <= tag_n;
			len_q    <= len_n;
			fmt_q    <= fmt_n;
			chan_q   <= chan_n;
			rate_q   <= rate_n;
			bits_q   <= bits_n;
			remain_q <= rem_n;
			pad_q    <= pad_n;
		end
	end

endmodule

FILE: hw/rtl/whp_out_q.sv
// ----------------------------------------------------------------------------
// whp_out_q
// Two-entry result queue between the parser and the result consumer.
// ----------------------------------------------------------------------------
module whp_out_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  whp_pkg::out_item_t wr_item,
	output logic               wr_ready,
	output logic               empty,
	input  logic               pop,
	output whp_pkg::out_item_t rd_item
);
	import whp_pkg::*;

	out_item_t  mem_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign empty    = (count_q == 2'd0);
	assign do_rd    = pop && !empty;
	// a slot frees up in the same cycle when the consumer takes the head
	assign wr_ready = (count_q != 2'(Q_DEPTH)) || do_rd;
	assign do_wr    = wr_en && wr_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/wav_header_parser_top.sv
// ----------------------------------------------------------------------------
// wav_header_parser_top
// Streaming RIFF/WAVE header parser and payload gate, one byte in and one
// result out per transfer.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------
//   item     | in        | push / full       | in_item_t  (byte + marks)
//   result   | out       | empty / pop       | out_item_t (status, fields)
//
// One byte per cycle sustained while the consumer keeps popping; a byte is
// registered in the input queue and its result in the result queue, from
// which it can be popped. The parser state update (tag compare, 32-bit chunk
// offset compare and count-down) is combinational for each byte.
// Reset returns the parser to the RIFF tag phase and empties both queues.
// A stalled consumer fills the result queue, then the input queue, after
// which full rises; no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module wav_header_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  whp_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output whp_pkg::out_item_t result
);
	import whp_pkg::*;

	logic      q_valid;
	in_item_t  q_item;
	logic      q_take;
	logic      res_ready;
	logic      res_push;
	out_item_t res_item;

	// input queue
	whp_in_q u_in_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.wr_item  (item),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_take  (q_take)
	);

	// parser engine
	whp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.in_take   (q_take),
		.out_ready (res_ready),
		.out_push  (res_push),
		.out_item  (res_item)
	);

	// result queue
	whp_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_push),
		.wr_item  (res_item),
		.wr_ready (res_ready),
		.empty    (empty),
		.pop      (pop),
		.rd_item  (result)
	);

endmodule
